@@ design/b64d_pkg.sv @@
// Types, codes and character helpers shared by the base64 stream decoder.
`default_nettype none

package b64d_pkg;

    // Decoder modes
    localparam logic [1:0] MODE_PREFIX = 2'd0;
    localparam logic [1:0] MODE_DECODE = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_NOCOMMA  = 2'd3;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_EQ       = 8'h3D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_Z     = 8'h5A;
    localparam logic [7:0] CH_LO_A     = 8'h61;
    localparam logic [7:0] CH_LO_Z     = 8'h7A;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LO_D     = 8'h64;
    localparam logic [7:0] CH_LO_T     = 8'h74;
    localparam logic [7:0] CH_COLON    = 8'h3A;

    localparam logic [2:0] PREFIX_LAST = 3'd4;   // position of ':' in "data:"
    localparam int         HELD_MAX    = 3;
    localparam int         RES_MAX     = 4;      // results one character can cause
    localparam int         QDEPTH      = 4;
    localparam int         QPTR_W      = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last_of_run;
    } out_t;

    typedef struct packed {
        logic [7:0] res_byte;
        logic [1:0] status;
    } res_t;

    // All results caused by one character, in delivery order
    typedef struct packed {
        res_t [RES_MAX-1:0] res;
        logic [2:0]         count;
    } run_t;

    // {valid, six-bit digit}
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        logic       ok;
        d  = 8'd0;
        ok = 1'b1;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + 8'd26;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO + 8'd52;
        end else if (c == CH_PLUS) begin
            d = 8'd62;
        end else if (c == CH_SLASH) begin
            d = 8'd63;
        end else begin
            ok = 1'b0;
        end
        return {ok, d[5:0]};
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CH_LO_D;
            3'd1:    ch = CH_LO_A;
            3'd2:    ch = CH_LO_T;
            3'd3:    ch = CH_LO_A;
            3'd4:    ch = CH_COLON;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ design/base64_stream_decoder.sv @@
// Top level of the streaming base64 decoder.
`default_nettype none

// Streaming base64 decoder: one text character per request on s_, results on m_.
// A character is taken every cycle while the four-entry run queue has room; the front
// end decodes it in that cycle and queues all results it causes as one run. The back end
// delivers one result per cycle, unless m_ready stalls it, from the head run through the
// output register; a character causes k results (k is 0 to 4, mostly 0 or 1), and the
// first result is stored in the run queue, then in the output register. Bytes come out as
// status 0; the character flagged end_of_text closes the stream with a status result
// (1 ok, 2 invalid character, 3 "data:" prefix without comma), last_of_run marks the final
// result of each character. After a status of 2 the stream's bytes should be discarded.
module base64_stream_decoder import b64d_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire in_t  s_data,
    input  wire logic s_valid,
    output logic      s_ready,
    output out_t      m_data,
    output logic      m_valid,
    input  wire logic m_ready
);

    logic push_valid;
    run_t push_run;
    logic q_full;
    logic q_empty;
    logic pop;
    run_t head;

    b64d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_run   (push_run)
    );

    b64d_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_run (push_run),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    b64d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule

`default_nettype wire

@@ design/b64d_front.sv @@
// Front end: accepts characters, keeps the decoding state and builds each character's run of results.
`default_nettype none

module b64d_front import b64d_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire in_t  s_data,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic q_full,
    output logic      push_valid,
    output run_t      push_run
);

    logic [11:0] acc_reg,  acc_next;
    logic [2:0]  pend_reg, pend_next;
    logic [2:0]  pos_reg,  pos_next;
    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hc_reg,   hc_next;
    logic        err_reg,  err_next;
    logic [7:0]  held_reg  [HELD_MAX];
    logic [7:0]  held_next [HELD_MAX];

    logic        accept;
    logic [7:0]  c;
    logic        last;
    logic [6:0]  dg;
    logic [11:0] acc_d;
    logic [3:0]  pend6;
    logic [3:0]  pend_sub;
    logic        byte_rdy;
    logic [11:0] acc_sh;
    logic [7:0]  dec_byte;
    logic        do_decode;
    logic        hold;
    logic        rel_mis;
    logic        release_en;
    logic [1:0]  rel_n;
    logic        emit;
    logic [1:0]  fin_status;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.text_char;
    assign last    = s_data.end_of_text;
    assign dg      = digit_of(c);

    // Candidate decode of the current character against the present accumulator
    assign acc_d    = {acc_reg[5:0], dg[5:0]};
    assign pend6    = {1'b0, pend_reg} + 4'd6;
    assign byte_rdy = pend6 >= 4'd8;
    assign pend_sub = pend6 - 4'd8;
    assign acc_sh   = acc_d >> pend_sub[2:0];
    assign dec_byte = acc_sh[7:0];

    always_comb begin
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        pos_next   = pos_reg;
        mode_next  = mode_reg;
        hc_next    = hc_reg;
        err_next   = err_reg;
        for (int i = 0; i < HELD_MAX; i++) begin
            held_next[i] = held_reg[i];
        end
        do_decode  = 1'b0;
        hold       = 1'b0;
        rel_mis    = 1'b0;
        emit       = 1'b0;

        unique case (mode_reg)
            MODE_PREFIX: begin
                if (c == prefix_char(pos_reg)) begin
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == PREFIX_LAST) begin
                        mode_next = MODE_SKIP;
                        acc_next  = 12'd0;
                        pend_next = 3'd0;
                        hc_next   = 2'd0;
                    end else begin
                        do_decode = 1'b1;
                        hold      = 1'b1;
                    end
                end else begin
                    mode_next = MODE_DECODE;
                    rel_mis   = 1'b1;
                    do_decode = 1'b1;
                end
            end
            MODE_DECODE: begin
                do_decode = 1'b1;
            end
            MODE_SKIP: begin
                if (c == CH_COMMA) begin
                    mode_next = MODE_DECODE;
                    acc_next  = 12'd0;
                    pend_next = 3'd0;
                end
            end
            MODE_STOP: begin
            end
            default: begin
            end
        endcase

        if (do_decode) begin
            priority if (c == CH_EQ) begin
                mode_next = MODE_STOP;
            end else if (c == CH_LF || c == CH_CR || c == CH_SP) begin
            end else if (!dg[6]) begin
                err_next  = 1'b1;
                mode_next = MODE_STOP;
            end else begin
                acc_next  = acc_d;
                pend_next = byte_rdy ? pend_sub[2:0] : pend6[2:0];
                if (byte_rdy) begin
                    if (hold) begin
                        if (hc_reg < 2'(HELD_MAX)) begin
                            held_next[hc_reg] = dec_byte;
                            hc_next           = hc_reg + 2'd1;
                        end
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
        end

        // Held bytes go out on a prefix mismatch, or when the text ends mid-prefix
        release_en = rel_mis || (last && mode_next == MODE_PREFIX);
        rel_n      = release_en ? hc_next : 2'd0;
        if (release_en) begin
            hc_next = 2'd0;
        end

        if (err_next) begin
            fin_status = ST_INVALID;
        end else if (mode_next == MODE_SKIP) begin
            fin_status = ST_NOCOMMA;
        end else begin
            fin_status = ST_OK;
        end

        for (int k = 0; k < RES_MAX; k++) begin
            if (k < 3'(rel_n) && k < HELD_MAX) begin
                push_run.res[k] = '{res_byte: held_next[k], status: ST_DATA};
            end else if (emit && k == 3'(rel_n)) begin
                push_run.res[k] = '{res_byte: dec_byte, status: ST_DATA};
            end else begin
                push_run.res[k] = '{res_byte: 8'd0, status: fin_status};
            end
        end
        push_run.count = {1'b0, rel_n} + {2'b00, emit} + {2'b00, last};

        if (last) begin
            acc_next  = 12'd0;
            pend_next = 3'd0;
            pos_next  = 3'd0;
            mode_next = MODE_PREFIX;
            hc_next   = 2'd0;
            err_next  = 1'b0;
        end
    end

    assign push_valid = accept && (push_run.count != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= 12'd0;
            pend_reg <= 3'd0;
            pos_reg  <= 3'd0;
            mode_reg <= MODE_PREFIX;
            hc_reg   <= 2'd0;
            err_reg  <= 1'b0;
        end else if (accept) begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
            hc_reg   <= hc_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < HELD_MAX; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (push_run.count <= 3'(RES_MAX)))
        else $error("run longer than the result budget");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last) |=> (mode_reg == MODE_PREFIX && pos_reg == 3'd0 &&
                              hc_reg == 2'd0 && !err_reg && pend_reg == 3'd0))
        else $error("stream state not cleared after end of text");

    a_end_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last) |-> push_valid)
        else $error("end of text produced no status request");

endmodule

`default_nettype wire

@@ design/b64d_queue.sv @@
// Short queue of result runs between front and back end.
`default_nettype none

module b64d_queue import b64d_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire run_t push_run,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output run_t      head
);

    run_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == (QPTR_W+1)'(QDEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == QPTR_W'(QDEPTH-1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == QPTR_W'(QDEPTH-1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_run;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

@@ design/b64d_back.sv @@
// Back end: one result per cycle from each queued run through an output register, unless stalled.
`default_nettype none

module b64d_back import b64d_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_empty,
    input  wire run_t head,
    output logic      pop,
    output out_t      m_data,
    output logic      m_valid,
    input  wire logic m_ready
);

    logic [1:0] sub_reg;
    logic       m_valid_reg;
    out_t       m_data_reg;
    logic       load;
    logic       run_last;
    res_t       cur;

    assign load     = !m_valid_reg || m_ready;
    assign cur      = head.res[sub_reg];
    assign run_last = {1'b0, sub_reg} == (head.count - 3'd1);
    assign pop      = load && !q_empty && run_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= !q_empty;
            if (!q_empty) begin
                sub_reg <= run_last ? 2'd0 : sub_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !q_empty) begin
            m_data_reg <= '{out_byte: cur.res_byte, status: cur.status,
                            last_of_run: run_last};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid_reg && m_data_reg.last_of_run))
        else $error("run retired without a last-of-run result");

    a_sub_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> ({1'b0, sub_reg} < head.count))
        else $error("result index beyond run length");

    a_status_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != ST_DATA) |-> (m_data_reg.out_byte == 8'd0))
        else $error("status result carries a non-zero byte");

endmodule

`default_nettype wire
